@@ src/sdbm_pkg.sv @@
// Shared constants, types and state codes for the second-derivative beat marker.
package sdbm_pkg;

  localparam int RING_DEPTH = 64;
  localparam int WINDOW = 32;
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W = 16;
  localparam int COUNT_W = 32;
  localparam int CNT_W = $clog2(WINDOW);
  localparam int PROD_W = 2 * SAMPLE_W + 2;

  localparam logic signed [SAMPLE_W-1:0] DATA_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] DATA_MIN = 16'sh8000;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 16'd1638;

  typedef logic signed [SAMPLE_W-1:0] data_t;

  typedef struct packed {
    logic  shift;
    logic  load_new;
    data_t din;
  } ring_ctrl_t;

  typedef struct packed {
    data_t leaving;
    data_t scan_min;
    data_t scan_max;
  } ring_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

endpackage

@@ src/sdbm_cell.sv @@
// One ring cell: a stored second difference plus a stage of the min/max scan chain.
module sdbm_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  sdbm_pkg::data_t     din,
  input  sdbm_pkg::data_t     acc_min_in,
  input  sdbm_pkg::data_t     acc_max_in,
  output sdbm_pkg::data_t     data,
  output sdbm_pkg::data_t     acc_min,
  output sdbm_pkg::data_t     acc_max
);

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (shift) begin
      data <= din;
    end
  end

  always_ff @(posedge clk) begin
    acc_min <= (data < acc_min_in) ? data : acc_min_in;
    acc_max <= (data > acc_max_in) ? data : acc_max_in;
  end

endmodule

@@ src/sdbm_ring.sv @@
// Rotating chain of cells that holds the second-difference history and scans its window.
module sdbm_ring (
  input  logic                 clk,
  input  logic                 rst,
  input  sdbm_pkg::ring_ctrl_t ctrl,
  output sdbm_pkg::ring_stat_t stat
);

  sdbm_pkg::data_t data [sdbm_pkg::RING_DEPTH];
  sdbm_pkg::data_t acc_min [sdbm_pkg::RING_DEPTH];
  sdbm_pkg::data_t acc_max [sdbm_pkg::RING_DEPTH];

  for (genvar k = 0; k < sdbm_pkg::RING_DEPTH; k++) begin : g_cell
    sdbm_pkg::data_t din;
    sdbm_pkg::data_t min_in;
    sdbm_pkg::data_t max_in;

    if (k == 0) begin : g_head
      // Slots skipped by early samples keep their old contents as the ring rotates.
      assign din = ctrl.load_new ? ctrl.din : data[sdbm_pkg::RING_DEPTH-1];
      assign min_in = sdbm_pkg::DATA_MAX;
      assign max_in = sdbm_pkg::DATA_MIN;
    end else begin : g_body
      assign din = data[k-1];
      assign min_in = acc_min[k-1];
      assign max_in = acc_max[k-1];
    end

    sdbm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (ctrl.shift),
      .din        (din),
      .acc_min_in (min_in),
      .acc_max_in (max_in),
      .data       (data[k]),
      .acc_min    (acc_min[k]),
      .acc_max    (acc_max[k])
    );
  end

  assign stat.leaving  = data[sdbm_pkg::WINDOW];
  assign stat.scan_min = acc_min[sdbm_pkg::WINDOW-1];
  assign stat.scan_max = acc_max[sdbm_pkg::WINDOW-1];

endmodule

@@ src/ppg_second_derivative_beat_marker.sv @@
// Top level of the second-derivative beat marker for optical heart-rate samples.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    sample
//   output   out        out_valid / out_stall  beat_flag, gradient, second_difference,
//                                              derivs_valid, window_ready, sample_index
//   config   in         cfg_valid / cfg_ready  cfg_data (threshold_fraction)
//
// A request runs through CHECK, MUL and EMIT when neither window extreme leaves, and
// through CHECK, SCAN, MUL and EMIT when one does, SCAN waiting on WINDOW ring cells.
// Requests before the window fills go from CHECK straight to EMIT.
// Reset is synchronous; the ring clears at once and no clearing pass is needed.
// A new request is taken while a finished result waits in the output register;
// the result is loaded once that register is free.
module ppg_second_derivative_beat_marker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sdbm_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                beat_flag,
  output logic signed [sdbm_pkg::SAMPLE_W-1:0] gradient,
  output logic signed [sdbm_pkg::SAMPLE_W-1:0] second_difference,
  output logic                                derivs_valid,
  output logic                                window_ready,
  output logic [sdbm_pkg::COUNT_W-1:0]        sample_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sdbm_pkg::FRAC_W-1:0]         cfg_data
);

  sdbm_pkg::state_t state;
  logic [sdbm_pkg::CNT_W-1:0] cnt;
  logic [sdbm_pkg::COUNT_W-1:0] sample_count;
  logic [sdbm_pkg::FRAC_W-1:0] frac;
  sdbm_pkg::data_t s1, s2, s3;
  sdbm_pkg::data_t deri_r, grad_r, dmin, dmax;
  logic valid_r, ready_r, min_hit, max_hit;
  logic [sdbm_pkg::COUNT_W-1:0] index_r;
  logic signed [sdbm_pkg::SAMPLE_W:0] diff_r;
  logic signed [sdbm_pkg::PROD_W-1:0] prod_r;

  logic accept, load_out, valid_now, ready_now;
  logic signed [sdbm_pkg::SAMPLE_W:0] grad_diff;
  sdbm_pkg::data_t deri_now, grad_now, range;
  logic signed [sdbm_pkg::PROD_W-1:0] lhs;
  sdbm_pkg::ring_ctrl_t ring_ctrl;
  sdbm_pkg::ring_stat_t ring_stat;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != sdbm_pkg::ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign load_out = (state == sdbm_pkg::ST_EMIT) && (!out_valid || !out_stall);

  assign valid_now = |sample_count[sdbm_pkg::COUNT_W-1:2];
  assign ready_now = valid_now && (sample_count >= sdbm_pkg::COUNT_W'(sdbm_pkg::WINDOW));
  assign grad_diff = {sample[sdbm_pkg::SAMPLE_W-1], sample} - {s2[sdbm_pkg::SAMPLE_W-1], s2};
  assign grad_now = grad_diff[sdbm_pkg::SAMPLE_W:1];
  assign deri_now = s3 - (s2 <<< 1) + s1;
  assign range = dmax - dmin;
  assign lhs = sdbm_pkg::PROD_W'({diff_r, 16'b0});

  assign ring_ctrl.shift = accept;
  assign ring_ctrl.load_new = valid_now;
  assign ring_ctrl.din = deri_now;

  sdbm_ring u_ring (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ring_ctrl),
    .stat (ring_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frac <= sdbm_pkg::FRAC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frac <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdbm_pkg::ST_IDLE;
      cnt <= '0;
      sample_count <= '0;
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      dmin <= sdbm_pkg::DATA_MAX;
      dmax <= sdbm_pkg::DATA_MIN;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        sdbm_pkg::ST_IDLE: begin
          if (accept) begin
            sample_count <= sample_count + 1'b1;
            s1 <= sample;
            s2 <= s1;
            s3 <= s2;
            state <= sdbm_pkg::ST_CHECK;
          end
        end
        sdbm_pkg::ST_CHECK: begin
          if (!ready_r) begin
            state <= sdbm_pkg::ST_EMIT;
          end else if ((dmin != ring_stat.leaving) && (dmax != ring_stat.leaving)) begin
            if (deri_r < dmin) dmin <= deri_r;
            if (deri_r > dmax) dmax <= deri_r;
            state <= sdbm_pkg::ST_MUL;
          end else begin
            cnt <= sdbm_pkg::CNT_W'(sdbm_pkg::WINDOW - 1);
            state <= sdbm_pkg::ST_SCAN;
          end
        end
        sdbm_pkg::ST_SCAN: begin
          if (cnt == '0) begin
            if (min_hit) begin
              dmin <= ring_stat.scan_min;
            end else if (deri_r < dmin) begin
              dmin <= deri_r;
            end
            if (max_hit) begin
              dmax <= ring_stat.scan_max;
            end else if (deri_r > dmax) begin
              dmax <= deri_r;
            end
            state <= sdbm_pkg::ST_MUL;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        sdbm_pkg::ST_MUL: begin
          state <= sdbm_pkg::ST_EMIT;
        end
        sdbm_pkg::ST_EMIT: begin
          if (load_out) state <= sdbm_pkg::ST_IDLE;
        end
        default: begin
          state <= sdbm_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      valid_r <= valid_now;
      ready_r <= ready_now;
      index_r <= sample_count;
      deri_r <= valid_now ? deri_now : '0;
      grad_r <= valid_now ? grad_now : '0;
    end
    if (state == sdbm_pkg::ST_CHECK) begin
      min_hit <= (dmin == ring_stat.leaving);
      max_hit <= (dmax == ring_stat.leaving);
    end
    if (state == sdbm_pkg::ST_MUL) begin
      diff_r <= {deri_r[sdbm_pkg::SAMPLE_W-1], deri_r} - {dmin[sdbm_pkg::SAMPLE_W-1], dmin};
      prod_r <= sdbm_pkg::PROD_W'(range * $signed({1'b0, frac}));
    end
    if (load_out) begin
      beat_flag <= ready_r && (lhs < prod_r);
      gradient <= grad_r;
      second_difference <= deri_r;
      derivs_valid <= valid_r;
      window_ready <= ready_r;
      sample_index <= index_r;
    end
  end

endmodule

@@ src/sdbm_checker.sv @@
// Port-level checks for the beat marker and the bind that attaches them.
module sdbm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                beat_flag,
  input logic signed [sdbm_pkg::SAMPLE_W-1:0] gradient,
  input logic signed [sdbm_pkg::SAMPLE_W-1:0] second_difference,
  input logic                                derivs_valid,
  input logic                                window_ready,
  input logic [sdbm_pkg::COUNT_W-1:0]        sample_index
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on two cycles in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_index) && $stable(beat_flag))
    else $error("stalled result changed");

  a_window_implies_derivs: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_ready |-> derivs_valid)
    else $error("window ready without derivatives");

  a_early_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !derivs_valid |-> gradient == '0 && second_difference == '0 && !beat_flag)
    else $error("early result carries nonzero fields");

endmodule

bind ppg_second_derivative_beat_marker sdbm_checker u_sdbm_checker (.*);
